FILE: design/tta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_pkg: shared types and constants of the adaptive Taylor tangent block
// Widths, fixed constants, datapath command codes, controller states and the
// power-of-ten table.
// ----------------------------------------------------------------------------
package tta_pkg;

    localparam int WORD_W   = 64;
    localparam int DWORD_W  = 128;
    localparam int ANGLE_W  = 24;
    localparam int TOL_W    = 32;
    localparam int TAN_W    = 32;
    localparam int STATUS_W = 2;
    localparam int ROUND_W  = 5;

    localparam int MAX_TERMS_DEF  = 12;
    localparam int MAX_ROUNDS_DEF = 10;
    localparam int FRAC_BITS_DEF  = 30;

    // pi * 10^9 and 180 * 10^9 for the degree to radian conversion
    localparam logic [WORD_W-1:0] PI_E9     = 64'd3141592654;
    localparam logic [WORD_W-1:0] CONV_DEN  = 64'd180000000000;
    localparam logic [WORD_W-1:0] CONV_HALF = 64'd90000000000;
    // reciprocal of the conversion divisor is scaled by 2^RCP_SHIFT
    localparam int               RCP_SHIFT = 100;
    localparam logic [WORD_W-1:0] PCT_SCALE = 64'd50;
    localparam int               RT_SHIFT  = 24;
    localparam logic [WORD_W-1:0] TAN_SCALE = 64'd131072;

    localparam logic [TAN_W-1:0] TAN_POS_LIM = 32'h7FFF_FFFF;
    localparam logic [TAN_W-1:0] TAN_NEG_LIM = 32'h8000_0000;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_SAT   = 2'd1,
        ST_LIMIT = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_CONV,
        OP_MUL_RCP,
        OP_X_SET,
        OP_X_ADD,
        OP_MUL_X2,
        OP_X2_SET,
        OP_SIN_INIT,
        OP_COS_INIT,
        OP_MUL_TERM,
        OP_DIV_TERM,
        OP_TERM_SET,
        OP_ACC,
        OP_MUL_TEST,
        OP_SER_END,
        OP_NEXT_TERM,
        OP_MUL_RT1,
        OP_DIV_RT,
        OP_RT_Q,
        OP_MUL_C2,
        OP_C2_SET,
        OP_MUL_RHS,
        OP_ROUND_END,
        OP_ROUND_LAST,
        OP_NEXT_ROUND,
        OP_OUT_ZERO,
        OP_MUL_TAN,
        OP_DIV_TAN,
        OP_OUT_TAN
    } dp_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CONV_M,
        S_CONV_MW,
        S_CONV_RW,
        S_CONV_QW,
        S_X2_M,
        S_X2_MW,
        S_ROUND,
        S_TERM_CHK,
        S_TERM_M,
        S_TERM_MW,
        S_TERM_DW,
        S_ACC,
        S_TEST_M,
        S_TEST_MW,
        S_COS,
        S_RT_M1,
        S_RT_M1W,
        S_RT_DW,
        S_RT_M2,
        S_RT_M2W,
        S_RT_M3,
        S_RT_M3W,
        S_FIN,
        S_FIN_MW,
        S_FIN_DW
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic need_upd;   // term must be advanced before accumulating
        logic conv;       // series stop test passes
        logic last_term;
        logic odd;        // sine series in progress
        logic pass;       // round stop test passes
        logic last_round;
        logic ca_zero;
    } dp_stat_t;

    function automatic logic [WORD_W-1:0] pow10(input logic [ROUND_W-1:0] n);
        logic [WORD_W-1:0] v;
        case (n)
            5'd0:    v = 64'd1;
            5'd1:    v = 64'd10;
            5'd2:    v = 64'd100;
            5'd3:    v = 64'd1000;
            5'd4:    v = 64'd10000;
            5'd5:    v = 64'd100000;
            5'd6:    v = 64'd1000000;
            5'd7:    v = 64'd10000000;
            5'd8:    v = 64'd100000000;
            5'd9:    v = 64'd1000000000;
            5'd10:   v = 64'd10000000000;
            5'd11:   v = 64'd100000000000;
            5'd12:   v = 64'd1000000000000;
            5'd13:   v = 64'd10000000000000;
            5'd14:   v = 64'd100000000000000;
            5'd15:   v = 64'd1000000000000000;
            5'd16:   v = 64'd10000000000000000;
            default: v = 64'd100000000000000000;
        endcase
        return v;
    endfunction

endpackage

FILE: design/taylor_tangent_adaptive.sv
`timescale 1ns / 1ps
// Latency: data dependent. Degree conversion takes three multiplies; each
// advanced series term takes a multiply, a short (64-bit) term division and a
// stop-test multiply; each round test includes a full (128-bit) division; the
// tangent is finished by a full division.
// Throughput: one transaction at a time; start is taken only while busy is low.
// Reset: asynchronous, active low; returns to idle with no result pending.
// The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
// taylor_tangent_adaptive: tangent from adaptive Taylor series of sin and cos
// Degrees in, saturating Q16.16 tangent out with status and round count.
// ----------------------------------------------------------------------------
module taylor_tangent_adaptive #(
    parameter int MAX_TERMS  = tta_pkg::MAX_TERMS_DEF,
    parameter int MAX_ROUNDS = tta_pkg::MAX_ROUNDS_DEF,
    parameter int FRAC_BITS  = tta_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [tta_pkg::ANGLE_W-1:0]  angle_deg,
    input  logic [tta_pkg::TOL_W-1:0]           tolerance,
    output logic                                done,
    output logic signed [tta_pkg::TAN_W-1:0]    tan_value,
    output logic [tta_pkg::STATUS_W-1:0]        status,
    output logic [tta_pkg::ROUND_W-1:0]         rounds_used
);
    import tta_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // controller: one command per cycle, waits on unit done pulses
    tta_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // datapath: shared multiplier and bit-serial divider
    tta_datapath #(
        .MAX_TERMS  (MAX_TERMS),
        .MAX_ROUNDS (MAX_ROUNDS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .angle_deg   (angle_deg),
        .tolerance   (tolerance),
        .tan_value   (tan_value),
        .status      (status),
        .rounds_used (rounds_used),
        .done        (done)
    );

    // result strobe comes out after the controller is back in idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule

FILE: design/tta_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_mul: sequential 64 x 64 multiplier
// One 32 x 32 partial product per cycle, accumulated into a 128-bit product.
// ----------------------------------------------------------------------------
module tta_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tta_pkg::WORD_W-1:0]  a,
    input  logic [tta_pkg::WORD_W-1:0]  b,
    output logic [tta_pkg::DWORD_W-1:0] prod,
    output logic                        done
);
    import tta_pkg::*;

    logic [WORD_W-1:0]  a_reg;
    logic [WORD_W-1:0]  b_reg;
    logic [DWORD_W-1:0] acc_reg;
    logic [1:0]         step_reg;
    logic               run_reg;
    logic               done_reg;

    logic [31:0]        op_a;
    logic [31:0]        op_b;
    logic [63:0]        pp;
    logic [DWORD_W-1:0] pp_sh;

    always_comb
    begin
        op_a = step_reg[1] ? a_reg[63:32] : a_reg[31:0];
        op_b = step_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pp   = op_a * op_b;
        case (step_reg)
            2'd0:    pp_sh = {64'b0, pp};
            2'd3:    pp_sh = {pp, 64'b0};
            default: pp_sh = {32'b0, pp, 32'b0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            acc_reg <= acc_reg + pp_sh;
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

FILE: design/tta_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_div: restoring divider, one quotient bit per cycle
// 128-bit dividend over 128 steps, or a 64-bit dividend over 64 steps.
// ----------------------------------------------------------------------------
module tta_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        short_op,
    input  logic [tta_pkg::DWORD_W-1:0] num,
    input  logic [tta_pkg::WORD_W-1:0]  den,
    output logic [tta_pkg::DWORD_W-1:0] quo,
    output logic [tta_pkg::WORD_W-1:0]  rem,
    output logic                        done
);
    import tta_pkg::*;

    logic [DWORD_W-1:0] n_reg;
    logic [WORD_W-1:0]  d_reg;
    logic [WORD_W-1:0]  r_reg;
    logic [DWORD_W-1:0] q_reg;
    logic [6:0]         idx_reg;
    logic               run_reg;
    logic               done_reg;

    logic [WORD_W-1:0]  r_sh;
    logic               ge;

    always_comb
    begin
        r_sh = {r_reg[WORD_W-2:0], n_reg[DWORD_W-1]};
        // carry out of the shift means the partial remainder exceeds any divisor
        ge   = r_reg[WORD_W-1] || (r_sh >= d_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                idx_reg <= short_op ? 7'd63 : 7'd127;
            end
            else if (run_reg)
            begin
                idx_reg <= idx_reg - 7'd1;
                if (idx_reg == 7'd0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg <= short_op ? {num[WORD_W-1:0], {WORD_W{1'b0}}} : num;
            d_reg <= den;
            r_reg <= '0;
            q_reg <= '0;
        end
        else if (run_reg)
        begin
            n_reg <= {n_reg[DWORD_W-2:0], 1'b0};
            r_reg <= ge ? (r_sh - d_reg) : r_sh;
            q_reg <= {q_reg[DWORD_W-2:0], ge};
        end
    end

    assign quo  = q_reg;
    assign rem  = r_reg;
    assign done = done_reg;

endmodule

FILE: design/tta_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_datapath: operand registers, series state and result registers
// Executes one command per cycle from the controller; owns the shared
// multiplier and divider.
// ----------------------------------------------------------------------------
module tta_datapath #(
    parameter int MAX_TERMS  = tta_pkg::MAX_TERMS_DEF,
    parameter int MAX_ROUNDS = tta_pkg::MAX_ROUNDS_DEF,
    parameter int FRAC_BITS  = tta_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tta_pkg::dp_cmd_t                    cmd,
    output tta_pkg::dp_stat_t                   stat,
    input  logic signed [tta_pkg::ANGLE_W-1:0]  angle_deg,
    input  logic [tta_pkg::TOL_W-1:0]           tolerance,
    output logic signed [tta_pkg::TAN_W-1:0]    tan_value,
    output logic [tta_pkg::STATUS_W-1:0]        status,
    output logic [tta_pkg::ROUND_W-1:0]         rounds_used,
    output logic                                done
);
    import tta_pkg::*;

    localparam int CNT_W = $clog2(MAX_TERMS);
    localparam int K_W   = $clog2(2 * MAX_TERMS + 2);

    // radians = dm * QA + floor((dm * RA + half) / den), the floor taken by
    // a reciprocal multiply that is exact over the whole angle range
    localparam logic [DWORD_W-1:0] CONV_A   = {64'b0, PI_E9} << (FRAC_BITS - 16);
    localparam logic [DWORD_W-1:0] CONV_D   = {64'b0, CONV_DEN};
    localparam logic [DWORD_W-1:0] CONV_QA  = CONV_A / CONV_D;
    localparam logic [DWORD_W-1:0] CONV_RA  = CONV_A % CONV_D;
    localparam logic [DWORD_W-1:0] CONV_RCP =
        ((DWORD_W'(1) << RCP_SHIFT) + CONV_D - DWORD_W'(1)) / CONV_D;

    logic [ANGLE_W-1:0] dm_reg;
    logic               neg_ang_reg;
    logic [TOL_W-1:0]   tol_reg;
    logic [WORD_W-1:0]  x_reg;
    logic [WORD_W-1:0]  x2_reg;
    logic [WORD_W-1:0]  term_reg;
    logic [WORD_W-1:0]  sum_reg;
    logic [K_W-1:0]     k_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               odd_reg;
    logic [WORD_W-1:0]  s_reg;
    logic [WORD_W-1:0]  c_reg;
    logic               ok_s_reg;
    logic               ok_c_reg;
    logic [ROUND_W-1:0] n_reg;
    logic [DWORD_W-1:0] rtq_reg;
    logic               rz_reg;
    logic [WORD_W-1:0]  c2_reg;
    logic               limit_reg;
    logic [TAN_W-1:0]   tan_reg;
    status_t            status_reg;
    logic [ROUND_W-1:0] rounds_reg;
    logic               done_reg;

    logic               mul_start;
    logic [WORD_W-1:0]  mul_a;
    logic [WORD_W-1:0]  mul_b;
    logic [DWORD_W-1:0] prod;
    logic               mul_done;
    logic               div_start;
    logic               div_short;
    logic [DWORD_W-1:0] div_num;
    logic [WORD_W-1:0]  div_den;
    logic [DWORD_W-1:0] quo;
    logic [WORD_W-1:0]  rem;
    logic               div_done;

    logic [DWORD_W-1:0] prod_rnd;
    logic [WORD_W-1:0]  prod_q;
    logic [WORD_W-1:0]  sum_mag;
    logic [WORD_W-1:0]  sa;
    logic [WORD_W-1:0]  ca;
    logic [WORD_W-1:0]  p10;
    logic [K_W-1:0]     k_up;
    logic [2*K_W-1:0]   kk;
    logic               tan_neg;
    logic [TAN_W-1:0]   tan_lim;
    logic               tan_sat;
    logic [TAN_W-1:0]   tan_mag;

    tta_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (prod),
        .done  (mul_done)
    );

    tta_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .short_op (div_short),
        .num      (div_num),
        .den      (div_den),
        .quo      (quo),
        .rem      (rem),
        .done     (div_done)
    );

    always_comb
    begin
        prod_rnd = prod + (DWORD_W'(1) << (FRAC_BITS - 1));
        prod_q   = prod_rnd[FRAC_BITS +: WORD_W];
        sum_mag  = sum_reg[WORD_W-1] ? (~sum_reg + 64'd1) : sum_reg;
        sa       = s_reg[WORD_W-1] ? (~s_reg + 64'd1) : s_reg;
        ca       = c_reg[WORD_W-1] ? (~c_reg + 64'd1) : c_reg;
        p10      = pow10(n_reg);
        k_up     = k_reg + K_W'(2);
        kk       = {{K_W{1'b0}}, k_up} * {{K_W{1'b0}}, k_up - K_W'(1)};
        tan_neg  = s_reg[WORD_W-1] ^ c_reg[WORD_W-1];
        tan_lim  = tan_neg ? TAN_NEG_LIM : TAN_POS_LIM;
        tan_sat  = (quo[DWORD_W-1:TAN_W] != '0) || (quo[TAN_W-1:0] > tan_lim);
        tan_mag  = tan_sat ? tan_lim : quo[TAN_W-1:0];
    end

    // unit operand selection
    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_short = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (cmd.op)
            OP_MUL_CONV:
            begin
                mul_start = 1'b1;
                mul_a     = {{(WORD_W-ANGLE_W){1'b0}}, dm_reg};
                mul_b     = CONV_RA[WORD_W-1:0];
            end
            OP_MUL_RCP:
            begin
                mul_start = 1'b1;
                mul_a     = prod[WORD_W-1:0] + CONV_HALF;
                mul_b     = CONV_RCP[WORD_W-1:0];
            end
            OP_X_SET:
            begin
                mul_start = 1'b1;
                mul_a     = {{(WORD_W-ANGLE_W){1'b0}}, dm_reg};
                mul_b     = CONV_QA[WORD_W-1:0];
            end
            OP_MUL_X2:
            begin
                mul_start = 1'b1;
                mul_a     = x_reg;
                mul_b     = x_reg;
            end
            OP_MUL_TERM:
            begin
                mul_start = 1'b1;
                mul_a     = term_reg;
                mul_b     = x2_reg;
            end
            OP_DIV_TERM:
            begin
                div_start = 1'b1;
                div_short = 1'b1;
                div_num   = {64'b0, prod_q};
                div_den   = WORD_W'(kk);
            end
            OP_MUL_TEST:
            begin
                mul_start = 1'b1;
                mul_a     = term_reg;
                mul_b     = {p10[WORD_W-2:0], 1'b0};
            end
            OP_MUL_RT1:
            begin
                mul_start = 1'b1;
                mul_a     = sa + ca;
                mul_b     = PCT_SCALE;
            end
            OP_DIV_RT:
            begin
                div_start = 1'b1;
                div_num   = prod << RT_SHIFT;
                div_den   = p10;
            end
            OP_MUL_C2:
            begin
                mul_start = 1'b1;
                mul_a     = ca;
                mul_b     = ca;
            end
            OP_MUL_RHS:
            begin
                mul_start = 1'b1;
                mul_a     = {32'b0, tol_reg};
                mul_b     = c2_reg;
            end
            OP_MUL_TAN:
            begin
                mul_start = 1'b1;
                mul_a     = sa;
                mul_b     = TAN_SCALE;
            end
            OP_DIV_TAN:
            begin
                div_start = 1'b1;
                div_num   = prod + {64'b0, ca};
                div_den   = {ca[WORD_W-2:0], 1'b0};
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd.op == OP_OUT_ZERO) || (cmd.op == OP_OUT_TAN);
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                neg_ang_reg <= angle_deg[ANGLE_W-1];
                dm_reg      <= angle_deg[ANGLE_W-1] ? (~angle_deg + 24'd1) : angle_deg;
                tol_reg     <= tolerance;
                n_reg       <= ROUND_W'(2);
            end
            OP_X_SET:
            begin
                x_reg <= {{(WORD_W-(DWORD_W-RCP_SHIFT)){1'b0}}, prod[DWORD_W-1:RCP_SHIFT]};
            end
            OP_X_ADD:     x_reg  <= x_reg + prod[WORD_W-1:0];
            OP_X2_SET:    x2_reg <= prod_q;
            OP_SIN_INIT:
            begin
                odd_reg  <= 1'b1;
                term_reg <= x_reg;
                sum_reg  <= '0;
                k_reg    <= K_W'(1);
                cnt_reg  <= '0;
            end
            OP_COS_INIT:
            begin
                odd_reg  <= 1'b0;
                term_reg <= WORD_W'(1) << FRAC_BITS;
                sum_reg  <= WORD_W'(1) << FRAC_BITS;
                k_reg    <= '0;
                cnt_reg  <= '0;
            end
            OP_DIV_TERM:  k_reg    <= k_up;
            OP_TERM_SET:  term_reg <= quo[WORD_W-1:0];
            OP_ACC:
            begin
                // signs alternate; cosine starts subtracting at its first term
                if (cnt_reg[0] ^ ~odd_reg)
                    sum_reg <= sum_reg - term_reg;
                else
                    sum_reg <= sum_reg + term_reg;
            end
            OP_SER_END:
            begin
                if (odd_reg)
                begin
                    s_reg    <= neg_ang_reg ? (~sum_reg + 64'd1) : sum_reg;
                    ok_s_reg <= stat.conv;
                end
                else
                begin
                    c_reg    <= sum_reg;
                    ok_c_reg <= stat.conv;
                end
            end
            OP_NEXT_TERM: cnt_reg <= cnt_reg + CNT_W'(1);
            OP_RT_Q:
            begin
                rtq_reg <= quo;
                rz_reg  <= (rem == '0);
            end
            OP_C2_SET:     c2_reg    <= prod_q;
            OP_ROUND_END:  limit_reg <= ~(ok_s_reg & ok_c_reg);
            OP_ROUND_LAST: limit_reg <= 1'b1;
            OP_NEXT_ROUND: n_reg     <= n_reg + ROUND_W'(1);
            OP_OUT_ZERO:
            begin
                tan_reg    <= s_reg[WORD_W-1] ? TAN_NEG_LIM : TAN_POS_LIM;
                status_reg <= limit_reg ? ST_LIMIT : ST_SAT;
                rounds_reg <= n_reg;
            end
            OP_OUT_TAN:
            begin
                tan_reg    <= tan_neg ? (~tan_mag + 32'd1) : tan_mag;
                status_reg <= limit_reg ? ST_LIMIT : (tan_sat ? ST_SAT : ST_OK);
                rounds_reg <= n_reg;
            end
            default:
            begin
                tan_reg <= tan_reg;
            end
        endcase
    end

    always_comb
    begin
        stat.mul_done   = mul_done;
        stat.div_done   = div_done;
        stat.need_upd   = (cnt_reg != '0) || !odd_reg;
        stat.conv       = (prod[DWORD_W-1:WORD_W] == '0) && (prod[WORD_W-1:0] <= sum_mag);
        stat.last_term  = (cnt_reg == CNT_W'(MAX_TERMS - 1));
        stat.odd        = odd_reg;
        stat.pass       = rz_reg ? (rtq_reg <= prod) : (rtq_reg < prod);
        stat.last_round = (n_reg >= ROUND_W'(MAX_ROUNDS + 1));
        stat.ca_zero    = (ca == '0);
    end

    assign tan_value   = tan_reg;
    assign status      = status_reg;
    assign rounds_used = rounds_reg;
    assign done        = done_reg;

endmodule

FILE: design/tta_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_ctrl: sequencing state machine
// Steps the datapath through conversion, series terms, round tests and the
// final division, or the saturated output when the cosine is zero.
// ----------------------------------------------------------------------------
module tta_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  tta_pkg::dp_stat_t  stat,
    output tta_pkg::dp_cmd_t   cmd
);
    import tta_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (start) state_next = S_CONV_M;
            S_CONV_M:   state_next = S_CONV_MW;
            S_CONV_MW:  if (stat.mul_done) state_next = S_CONV_RW;
            S_CONV_RW:  if (stat.mul_done) state_next = S_CONV_QW;
            S_CONV_QW:  if (stat.mul_done) state_next = S_X2_M;
            S_X2_M:     state_next = S_X2_MW;
            S_X2_MW:    if (stat.mul_done) state_next = S_ROUND;
            S_ROUND:    state_next = S_TERM_CHK;
            S_TERM_CHK: state_next = stat.need_upd ? S_TERM_M : S_ACC;
            S_TERM_M:   state_next = S_TERM_MW;
            S_TERM_MW:  if (stat.mul_done) state_next = S_TERM_DW;
            S_TERM_DW:  if (stat.div_done) state_next = S_ACC;
            S_ACC:      state_next = S_TEST_M;
            S_TEST_M:   state_next = S_TEST_MW;
            S_TEST_MW:
            begin
                if (stat.mul_done)
                begin
                    if (stat.conv || stat.last_term)
                        state_next = stat.odd ? S_COS : S_RT_M1;
                    else
                        state_next = S_TERM_CHK;
                end
            end
            S_COS:      state_next = S_TERM_CHK;
            S_RT_M1:    state_next = S_RT_M1W;
            S_RT_M1W:   if (stat.mul_done) state_next = S_RT_DW;
            S_RT_DW:    if (stat.div_done) state_next = S_RT_M2;
            S_RT_M2:    state_next = S_RT_M2W;
            S_RT_M2W:   if (stat.mul_done) state_next = S_RT_M3;
            S_RT_M3:    state_next = S_RT_M3W;
            S_RT_M3W:
            begin
                if (stat.mul_done)
                    state_next = (stat.pass || stat.last_round) ? S_FIN : S_ROUND;
            end
            S_FIN:      state_next = stat.ca_zero ? S_IDLE : S_FIN_MW;
            S_FIN_MW:   if (stat.mul_done) state_next = S_FIN_DW;
            S_FIN_DW:   if (stat.div_done) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op = OP_NONE;
        case (state_reg)
            S_IDLE:     if (start) cmd.op = OP_LOAD;
            S_CONV_M:   cmd.op = OP_MUL_CONV;
            S_CONV_MW:  if (stat.mul_done) cmd.op = OP_MUL_RCP;
            S_CONV_RW:  if (stat.mul_done) cmd.op = OP_X_SET;
            S_CONV_QW:  if (stat.mul_done) cmd.op = OP_X_ADD;
            S_X2_M:     cmd.op = OP_MUL_X2;
            S_X2_MW:    if (stat.mul_done) cmd.op = OP_X2_SET;
            S_ROUND:    cmd.op = OP_SIN_INIT;
            S_TERM_M:   cmd.op = OP_MUL_TERM;
            S_TERM_MW:  if (stat.mul_done) cmd.op = OP_DIV_TERM;
            S_TERM_DW:  if (stat.div_done) cmd.op = OP_TERM_SET;
            S_ACC:      cmd.op = OP_ACC;
            S_TEST_M:   cmd.op = OP_MUL_TEST;
            S_TEST_MW:
            begin
                if (stat.mul_done)
                    cmd.op = (stat.conv || stat.last_term) ? OP_SER_END : OP_NEXT_TERM;
            end
            S_COS:      cmd.op = OP_COS_INIT;
            S_RT_M1:    cmd.op = OP_MUL_RT1;
            S_RT_M1W:   if (stat.mul_done) cmd.op = OP_DIV_RT;
            S_RT_DW:    if (stat.div_done) cmd.op = OP_RT_Q;
            S_RT_M2:    cmd.op = OP_MUL_C2;
            S_RT_M2W:   if (stat.mul_done) cmd.op = OP_C2_SET;
            S_RT_M3:    cmd.op = OP_MUL_RHS;
            S_RT_M3W:
            begin
                if (stat.mul_done)
                begin
                    if (stat.pass)
                        cmd.op = OP_ROUND_END;
                    else if (stat.last_round)
                        cmd.op = OP_ROUND_LAST;
                    else
                        cmd.op = OP_NEXT_ROUND;
                end
            end
            S_FIN:      cmd.op = stat.ca_zero ? OP_OUT_ZERO : OP_MUL_TAN;
            S_FIN_MW:   if (stat.mul_done) cmd.op = OP_DIV_TAN;
            S_FIN_DW:   if (stat.div_done) cmd.op = OP_OUT_TAN;
            default:    cmd.op = OP_NONE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule
